// ===== design/bpb_pkg.sv =====
// Shared types and constants for the Bezier path bounds unit.
package bpb_pkg;

  // Fraction bits of the curve parameter t; t = 1.0 is 2**T_BITS.
  localparam int T_BITS = 30;
  localparam int DIV_STEPS = T_BITS + 1;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W = 6;

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_QUAD  = 2'd2;
  localparam logic [1:0] KIND_CUBIC = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               new_path;
    logic signed [31:0] pt1_x;
    logic signed [31:0] pt1_y;
    logic signed [31:0] pt2_x;
    logic signed [31:0] pt2_y;
    logic signed [31:0] pt3_x;
    logic signed [31:0] pt3_y;
  } bpb_in_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic               box_valid;
  } bpb_out_t;

  // Command and status between the sequencer and the divide/root unit.
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } bpb_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bpb_sts_t;

endpackage

// ===== design/bpb_iter_unit.sv =====
// Bit-serial unit for the root fraction division and the integer square root.
module bpb_iter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpb_pkg::bpb_cmd_t cmd_i,
  input  logic [63:0]       opa_i,
  input  logic [34:0]       opb_i,
  output bpb_pkg::bpb_sts_t sts_o,
  output logic [30:0]       res_o
);
  import bpb_pkg::*;

  logic [63:0]      acc_q, res_q, bit_q;
  logic [34:0]      den_q;
  logic             mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [63:0] sq_sum, dv_sub;
  logic        sq_ge, dv_ge;

  assign sq_sum = res_q + bit_q;
  assign sq_ge  = acc_q >= sq_sum;
  assign dv_ge  = acc_q >= {29'd0, den_q};
  assign dv_sub = acc_q - {29'd0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cmd_i.sqrt_mode ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= cmd_i.sqrt_mode;
      acc_q  <= opa_i;
      res_q  <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
      den_q  <= opb_i;
    end else if (busy_q) begin
      if (mode_q) begin
        // Restoring square root, two radicand bits per step.
        if (sq_ge) begin
          acc_q <= acc_q - sq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        // Restoring division, one quotient bit per step.
        acc_q <= (dv_ge ? dv_sub : acc_q) << 1;
        res_q <= {res_q[62:0], dv_ge};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = res_q[30:0];

endmodule

// ===== design/bezier_path_bounds_unit.sv =====
// Top level: running bounding box of a path of moves, lines and Bezier curves.
// A move or line word goes from the init state straight to the done state; per axis,
// a quadratic runs at most one divide, and a cubic at most one square root and two
// divides, each divide followed by a de Casteljau evaluation at the root it gives.
// One word is processed at a time; the next is taken once the result is registered.
// Reset clears the current point, the box and the box-valid flag to zero.
module bezier_path_bounds_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpb_pkg::bpb_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bpb_pkg::bpb_out_t out_word_o
);
  import bpb_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_AXIS  = 5'd2;
  localparam logic [4:0] S_COEF  = 5'd3;
  localparam logic [4:0] S_SHIFT = 5'd4;
  localparam logic [4:0] S_CSEL  = 5'd5;
  localparam logic [4:0] S_DISC1 = 5'd6;
  localparam logic [4:0] S_DISC2 = 5'd7;
  localparam logic [4:0] S_DISC3 = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_ROOT  = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_EMUL  = 5'd12;
  localparam logic [4:0] S_EACC  = 5'd13;
  localparam logic [4:0] S_EDROP = 5'd14;
  localparam logic [4:0] S_AFTER = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

  function automatic logic signed [31:0] shr_mag(input logic signed [35:0] v,
                                                 input logic [2:0] s);
    logic [35:0] m;
    logic [31:0] r;
    m = mag36(v) >> s;
    r = m[31:0];
    return v[35] ? 32'(-r) : 32'(r);
  endfunction

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [4:0] state_q, state_d;
  logic       out_valid_q;
  bpb_out_t   out_q;
  bpb_in_t    in_q;

  logic signed [31:0] cur_x_q, cur_y_q, lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  logic               seen_q;
  logic signed [31:0] sx_q, sy_q;
  logic               axis_q, second_q;
  logic signed [31:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [35:0] ca_q, cb_q, cc_q;
  logic signed [31:0] cas_q, cbs_q, ccs_q;
  logic signed [34:0] num_q, den_q;
  logic signed [63:0] sq_q;
  logic [30:0]        r_q, t_q;
  logic signed [31:0] w_q [4];
  logic [1:0]         lvl_q, lcnt_q, dcnt_q;
  logic signed [65:0] pr_q;

  bpb_cmd_t    cmd;
  bpb_sts_t    sts;
  logic [63:0] u_opa;
  logic [34:0] u_opb;
  logic [30:0] u_res;

  logic        is_curve, is_cubic;
  logic [1:0]  deg;
  logic        in_acc, out_acc, out_free;

  assign is_curve = in_q.req_type == KIND_QUAD || in_q.req_type == KIND_CUBIC;
  assign is_cubic = in_q.req_type == KIND_CUBIC;
  assign deg      = is_cubic ? 2'd3 : 2'd2;
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Start point and box after an optional new-path clear.
  logic signed [31:0] sx, sy, ex, ey, ax, ay, lo0x, lo0y, hi0x, hi0y;
  logic               seen0;
  always_comb begin
    seen0 = in_q.new_path ? 1'b0 : seen_q;
    sx    = in_q.new_path ? 32'sd0 : cur_x_q;
    sy    = in_q.new_path ? 32'sd0 : cur_y_q;
    unique case (in_q.req_type)
      KIND_QUAD: begin
        ex = in_q.pt2_x;
        ey = in_q.pt2_y;
      end
      KIND_CUBIC: begin
        ex = in_q.pt3_x;
        ey = in_q.pt3_y;
      end
      default: begin
        ex = in_q.pt1_x;
        ey = in_q.pt1_y;
      end
    endcase
    // A move or line adds its one point twice, which changes nothing.
    ax = is_curve ? sx : ex;
    ay = is_curve ? sy : ey;
    if (seen0) begin
      lo0x = smin(smin(lo_x_q, ax), ex);
      hi0x = smax(smax(hi_x_q, ax), ex);
      lo0y = smin(smin(lo_y_q, ay), ey);
      hi0y = smax(smax(hi_y_q, ay), ey);
    end else begin
      lo0x = smin(ax, ex);
      hi0x = smax(ax, ex);
      lo0y = smin(ay, ey);
      hi0y = smax(ay, ey);
    end
  end

  // Cubic derivative coefficients and their common normalizing shift.
  logic signed [35:0] ca_c, cb_c, cc_c;
  logic [35:0]        m_a, m_b, m_c, m_max;
  logic [2:0]         sh;
  always_comb begin
    ca_c = sx36(pd_q) - (sx36(pc_q) <<< 1) - sx36(pc_q)
         + (sx36(pb_q) <<< 1) + sx36(pb_q) - sx36(pa_q);
    cb_c = sx36(pc_q) - (sx36(pb_q) <<< 1) + sx36(pa_q);
    cc_c = sx36(pb_q) - sx36(pa_q);
    m_a = mag36(ca_q);
    m_b = mag36(cb_q);
    m_c = mag36(cc_q);
    m_max = m_a;
    if (m_b > m_max) m_max = m_b;
    if (m_c > m_max) m_max = m_c;
    sh = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if ((m_max >> (29 + k)) != 36'd0) sh = 3'(k);
    end
  end

  // Discriminant and root fraction checks.
  logic signed [63:0] disc;
  logic [34:0]        nm, dm;
  logic               skip;
  assign disc = sq_q - pr_q[63:0];
  assign nm   = num_q[34] ? 35'(-num_q) : 35'(num_q);
  assign dm   = den_q[34] ? 35'(-den_q) : 35'(den_q);
  assign skip = (den_q == 35'sd0) || (num_q != 35'sd0 && num_q[34] != den_q[34])
             || (nm > dm);

  // Shared multiplier with a registered product.
  logic signed [33:0] ma;
  logic signed [31:0] mb;
  logic signed [32:0] ldiff;
  assign ldiff = {w_q[1][31], w_q[1]} - {w_q[0][31], w_q[0]};
  always_comb begin
    unique case (state_q)
      S_DISC1: begin
        ma = {{2{cbs_q[31]}}, cbs_q};
        mb = cbs_q;
      end
      S_DISC2: begin
        ma = {{2{cas_q[31]}}, cas_q};
        mb = ccs_q;
      end
      S_EMUL: begin
        ma = {ldiff[32], ldiff};
        mb = {1'b0, t_q};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // One de Casteljau step: p + trunc((q - p) * t / 2**T_BITS).
  logic signed [63:0] prod;
  logic signed [63:0] qt;
  logic signed [32:0] lsum;
  logic signed [31:0] lres;
  assign prod = pr_q[63:0];
  assign qt   = prod[63] ? ((prod + 64'sd1073741823) >>> T_BITS) : (prod >>> T_BITS);
  assign lsum = {w_q[0][31], w_q[0]} + qt[32:0];
  assign lres = lsum[31:0];

  always_comb begin
    cmd.start     = (state_q == S_DISC3 && !disc[63]) || (state_q == S_ROOT && !skip);
    cmd.sqrt_mode = state_q == S_DISC3;
    u_opa = (state_q == S_DISC3) ? disc : {29'd0, nm};
    u_opb = dm;
  end

  bpb_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (u_opa),
    .opb_i  (u_opb),
    .sts_o  (sts),
    .res_o  (u_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_INIT;
      S_INIT:  state_d = is_curve ? S_AXIS : S_DONE;
      S_AXIS:  state_d = S_COEF;
      S_COEF:  state_d = is_cubic ? S_SHIFT : S_ROOT;
      S_SHIFT: state_d = S_CSEL;
      S_CSEL:  state_d = (cas_q == 32'sd0) ? S_ROOT : S_DISC1;
      S_DISC1: state_d = S_DISC2;
      S_DISC2: state_d = S_DISC3;
      S_DISC3: state_d = disc[63] ? S_NEXT : S_SQRT;
      S_SQRT:  if (sts.done) state_d = S_ROOT;
      S_ROOT:  state_d = skip ? S_AFTER : S_DIV;
      S_DIV:   if (sts.done) state_d = S_EMUL;
      S_EMUL:  state_d = S_EACC;
      S_EACC: begin
        if (lvl_q == 2'd1) state_d = S_AFTER;
        else if (lcnt_q == 2'd1) state_d = S_EDROP;
        else state_d = S_EMUL;
      end
      S_EDROP: if (dcnt_q == 2'd1) state_d = S_EMUL;
      S_AFTER: state_d = second_q ? S_ROOT : S_NEXT;
      S_NEXT:  state_d = axis_q ? S_DONE : S_AXIS;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      lo_x_q      <= '0;
      lo_y_q      <= '0;
      hi_x_q      <= '0;
      hi_y_q      <= '0;
      seen_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
      if (state_q == S_INIT) begin
        cur_x_q <= ex;
        cur_y_q <= ey;
        lo_x_q  <= lo0x;
        hi_x_q  <= hi0x;
        lo_y_q  <= lo0y;
        hi_y_q  <= hi0y;
        seen_q  <= 1'b1;
      end else if (state_q == S_EACC && lvl_q == 2'd1) begin
        if (axis_q) begin
          lo_y_q <= smin(lo_y_q, lres);
          hi_y_q <= smax(hi_y_q, lres);
        end else begin
          lo_x_q <= smin(lo_x_q, lres);
          hi_x_q <= smax(hi_x_q, lres);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q <= ma * mb;
    unique case (state_q)
      S_IDLE: if (in_acc) in_q <= in_word_i;
      S_INIT: begin
        sx_q   <= sx;
        sy_q   <= sy;
        axis_q <= 1'b0;
      end
      S_AXIS: begin
        pa_q <= axis_q ? sy_q : sx_q;
        pb_q <= axis_q ? in_q.pt1_y : in_q.pt1_x;
        pc_q <= axis_q ? in_q.pt2_y : in_q.pt2_x;
        pd_q <= axis_q ? in_q.pt3_y : in_q.pt3_x;
      end
      S_COEF: begin
        ca_q     <= ca_c;
        cb_q     <= cb_c;
        cc_q     <= cc_c;
        second_q <= 1'b0;
        num_q    <= sx35(pa_q) - sx35(pb_q);
        den_q    <= sx35(pa_q) - (sx35(pb_q) <<< 1) + sx35(pc_q);
      end
      S_SHIFT: begin
        cas_q <= shr_mag(ca_q, sh);
        cbs_q <= shr_mag(cb_q, sh);
        ccs_q <= shr_mag(cc_q, sh);
      end
      S_CSEL: begin
        // With no quadratic term the derivative is linear in t.
        num_q <= -sx35(ccs_q);
        den_q <= sx35(cbs_q) <<< 1;
      end
      S_DISC2: sq_q <= pr_q[63:0];
      S_SQRT: begin
        if (sts.done) begin
          r_q      <= u_res;
          second_q <= 1'b1;
          num_q    <= -sx35(cbs_q) + {4'd0, u_res};
          den_q    <= sx35(cas_q);
        end
      end
      S_DIV: begin
        if (sts.done) begin
          t_q    <= u_res;
          w_q[0] <= pa_q;
          w_q[1] <= pb_q;
          w_q[2] <= pc_q;
          w_q[3] <= pd_q;
          lvl_q  <= deg;
          lcnt_q <= deg;
        end
      end
      S_EACC: begin
        if (lvl_q != 2'd1) begin
          // Shift the working points down and append the new one.
          w_q[0] <= w_q[1];
          w_q[1] <= w_q[2];
          w_q[2] <= is_cubic ? w_q[3] : lres;
          w_q[3] <= is_cubic ? lres : w_q[3];
          if (lcnt_q == 2'd1) begin
            lvl_q  <= lvl_q - 2'd1;
            dcnt_q <= deg + 2'd1 - lvl_q;
          end else begin
            lcnt_q <= lcnt_q - 2'd1;
          end
        end
      end
      S_EDROP: begin
        w_q[0] <= w_q[1];
        w_q[1] <= w_q[2];
        w_q[2] <= w_q[3];
        dcnt_q <= dcnt_q - 2'd1;
        if (dcnt_q == 2'd1) lcnt_q <= lvl_q;
      end
      S_AFTER: begin
        if (second_q) begin
          second_q <= 1'b0;
          num_q    <= -sx35(cbs_q) - {4'd0, r_q};
          den_q    <= sx35(cas_q);
        end
      end
      S_NEXT: axis_q <= 1'b1;
      S_DONE: begin
        if (out_free) begin
          out_q.box_min_x <= lo_x_q;
          out_q.box_min_y <= lo_y_q;
          out_q.box_max_x <= hi_x_q;
          out_q.box_max_y <= hi_y_q;
          out_q.box_valid <= seen_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_unit_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !sts.busy)
    else $error("divide/root unit started while busy");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (lo_x_q <= hi_x_q && lo_y_q <= hi_y_q))
    else $error("bounding box edges out of order");

  a_out_box_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.box_valid)
    else $error("result word without a valid box");

  a_accept_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> $past(state_q == S_IDLE))
    else $error("segment started outside idle");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the Bezier path bounds unit: random and directed segments against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import bpb_pkg::*;

  localparam longint T_ONE = 64'sd1 << T_BITS;
  localparam longint RED_LIMIT = 64'sd1 << 30;
  localparam int IDLE_LIMIT = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  bpb_in_t  in_word_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bpb_out_t out_word_o;

  bezier_path_bounds_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  longint pos_x, pos_y, lo_x, lo_y, hi_x, hi_y;
  bit     have_point;
  bpb_out_t expected_boxes[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_recv = 1'b0;
  int  fail_count = 0;
  int  idle_cycles = 0;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint shift_mag(longint v, int s);
    longint m;
    m = abs64(v) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint unsigned res, bitv, x;
    x = v;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint interp(longint p, longint q, longint t);
    return p + ((q - p) * t) / T_ONE;
  endfunction

  // Returns 1 and the parameter when num/den lies in [0, 1].
  function automatic bit param_of(longint num, longint den, output longint t);
    longint un, ud;
    t = 0;
    if (den == 0) return 1'b0;
    if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
    un = abs64(num);
    ud = abs64(den);
    if (un > ud) return 1'b0;
    t = (un << T_BITS) / ud;
    return 1'b1;
  endfunction

  function automatic void widen(ref longint lo, ref longint hi, input longint v);
    if (v < lo) lo = v;
    if (v > hi) hi = v;
  endfunction

  function automatic void include_point(longint x, longint y);
    if (!have_point) begin
      lo_x = x; hi_x = x; lo_y = y; hi_y = y;
      have_point = 1'b1;
    end else begin
      widen(lo_x, hi_x, x);
      widen(lo_y, hi_y, y);
    end
  endfunction

  function automatic void quad_extreme(longint a, longint b, longint c,
                                       ref longint lo, ref longint hi);
    longint t;
    if (param_of(a - b, a - 2 * b + c, t))
      widen(lo, hi, interp(interp(a, b, t), interp(b, c, t), t));
  endfunction

  function automatic longint cubic_at(longint p1, longint p2, longint p3, longint p4,
                                      longint t);
    longint ab, bc, cd;
    ab = interp(p1, p2, t);
    bc = interp(p2, p3, t);
    cd = interp(p3, p4, t);
    return interp(interp(ab, bc, t), interp(bc, cd, t), t);
  endfunction

  function automatic void cubic_extreme(longint p1, longint p2, longint p3, longint p4,
                                        ref longint lo, ref longint hi);
    longint ca, cb, cc, m, t, d, r;
    int s;
    ca = p4 - 3 * p3 + 3 * p2 - p1;
    cb = p3 - 2 * p2 + p1;
    cc = p2 - p1;
    m = abs64(ca);
    if (abs64(cb) > m) m = abs64(cb);
    if (abs64(cc) > m) m = abs64(cc);
    s = 0;
    while ((m >>> s) >= RED_LIMIT) s++;
    ca = shift_mag(ca, s);
    cb = shift_mag(cb, s);
    cc = shift_mag(cc, s);
    if (ca == 0) begin
      if (param_of(-cc, 2 * cb, t)) widen(lo, hi, cubic_at(p1, p2, p3, p4, t));
      return;
    end
    d = cb * cb - ca * cc;
    if (d < 0) return;
    r = int_sqrt(d);
    if (param_of(-cb + r, ca, t)) widen(lo, hi, cubic_at(p1, p2, p3, p4, t));
    if (param_of(-cb - r, ca, t)) widen(lo, hi, cubic_at(p1, p2, p3, p4, t));
  endfunction

  function automatic bpb_out_t predict_box(bpb_in_t w);
    bpb_out_t o;
    longint x1, y1, x2, y2, x3, y3;
    x1 = longint'(w.pt1_x); y1 = longint'(w.pt1_y);
    x2 = longint'(w.pt2_x); y2 = longint'(w.pt2_y);
    x3 = longint'(w.pt3_x); y3 = longint'(w.pt3_y);
    if (w.new_path) begin
      pos_x = 0; pos_y = 0; lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
      have_point = 1'b0;
    end
    case (w.req_type)
      KIND_MOVE, KIND_LINE: begin
        include_point(x1, y1);
        pos_x = x1; pos_y = y1;
      end
      KIND_QUAD: begin
        include_point(pos_x, pos_y);
        include_point(x2, y2);
        quad_extreme(pos_x, x1, x2, lo_x, hi_x);
        quad_extreme(pos_y, y1, y2, lo_y, hi_y);
        pos_x = x2; pos_y = y2;
      end
      default: begin
        include_point(pos_x, pos_y);
        include_point(x3, y3);
        cubic_extreme(pos_x, x1, x2, x3, lo_x, hi_x);
        cubic_extreme(pos_y, y1, y2, y3, lo_y, hi_y);
        pos_x = x3; pos_y = y3;
      end
    endcase
    o.box_min_x = lo_x[31:0];
    o.box_min_y = lo_y[31:0];
    o.box_max_x = hi_x[31:0];
    o.box_max_y = hi_y[31:0];
    o.box_valid = have_point;
    return o;
  endfunction

  // Sends one word, idling first at the chosen rate; valid stays high for a next word.
  task automatic send_word(bpb_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_boxes.push_back(predict_box(w));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    bpb_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_boxes.size() == 0) begin
        $error("unexpected output word %h", out_word_o);
        fail_count++;
      end else begin
        e = expected_boxes.pop_front();
        if (out_word_o.box_min_x !== e.box_min_x) begin
          $error("box_min_x exp %h got %h", e.box_min_x, out_word_o.box_min_x);
          fail_count++;
        end
        if (out_word_o.box_min_y !== e.box_min_y) begin
          $error("box_min_y exp %h got %h", e.box_min_y, out_word_o.box_min_y);
          fail_count++;
        end
        if (out_word_o.box_max_x !== e.box_max_x) begin
          $error("box_max_x exp %h got %h", e.box_max_x, out_word_o.box_max_x);
          fail_count++;
        end
        if (out_word_o.box_max_y !== e.box_max_y) begin
          $error("box_max_y exp %h got %h", e.box_max_y, out_word_o.box_max_y);
          fail_count++;
        end
        if (out_word_o.box_valid !== e.box_valid) begin
          $error("box_valid exp %b got %b", e.box_valid, out_word_o.box_valid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic bpb_in_t rand_word();
    bpb_in_t w;
    w.req_type = 2'($urandom_range(3));
    w.new_path = ($urandom_range(9) == 0);
    w.pt1_x = rand_coord(); w.pt1_y = rand_coord();
    w.pt2_x = rand_coord(); w.pt2_y = rand_coord();
    w.pt3_x = rand_coord(); w.pt3_y = rand_coord();
    return w;
  endfunction

  function automatic bpb_in_t make_word(logic [1:0] k, logic np, int x1, int y1,
                                        int x2, int y2, int x3, int y3);
    bpb_in_t w;
    w.req_type = k; w.new_path = np;
    w.pt1_x = x1; w.pt1_y = y1; w.pt2_x = x2; w.pt2_y = y2;
    w.pt3_x = x3; w.pt3_y = y3;
    return w;
  endfunction

  // Drops valid, then waits until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_boxes.size() != 0);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_word(make_word(KIND_LINE, 1'b0, 100, -100, 0, 0, 0, 0));
    send_word(make_word(KIND_MOVE, 1'b1, 0, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_LINE, 1'b0, mx, mn, 0, 0, 0, 0));
    send_word(make_word(KIND_LINE, 1'b0, mn, mx, 0, 0, 0, 0));
    send_word(make_word(KIND_MOVE, 1'b1, 0, 0, 0, 0, 0, 0));
    // Quadratic with an interior peak, then one with a zero denominator.
    send_word(make_word(KIND_QUAD, 1'b0, 65536, 131072, 131072, 0, 0, 0));
    send_word(make_word(KIND_QUAD, 1'b0, 196608, 0, 262144, 0, 0, 0));
    // Quadratic whose root lies outside the segment.
    send_word(make_word(KIND_QUAD, 1'b0, 300000, 10, 400000, 20, 0, 0));
    send_word(make_word(KIND_QUAD, 1'b1, mx, mn, mn, mx, 0, 0));
    send_word(make_word(KIND_CUBIC, 1'b1, 0, 100000, 100000, 100000, 100000, 0));
    // Cubic with A zero after reduction, and one with a positive discriminant on both axes.
    send_word(make_word(KIND_CUBIC, 1'b0, 200000, 10, 300000, 20, 400000, 30));
    send_word(make_word(KIND_CUBIC, 1'b0, 100, 5000, 500, -5000, 600, 100));
    send_word(make_word(KIND_CUBIC, 1'b0, mx, mn, mn, mx, mx, mn));
    send_word(make_word(KIND_CUBIC, 1'b0, mn, mx, mx, mn, mn, mx));
    send_word(make_word(KIND_CUBIC, 1'b1, -1, -1, -1, -1, -1, -1));
    send_word(make_word(KIND_LINE, 1'b0, -1, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(rand_word());
  endtask

  // The receiver holds off long enough that the unit backs up onto its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      repeat (8) send_word(rand_word());
    join
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 76, 0);
    test_random(300, 0, 76);
    wait_drained();
    test_backpressure();
    test_random(300, 29, 29);
    wait_drained();
    repeat (500) @(posedge clk_i);
    if (fail_count == 0 && expected_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bpb_pkg.sv
design/bpb_iter_unit.sv
design/bezier_path_bounds_unit.sv
dv/tb_top.sv
